// ----- design/prq_pkg.sv -----
// Shared types and codes for the priority retry queue.
package prq_pkg;

	typedef enum logic [2:0] {
		MODE_ENQ     = 3'd0,
		MODE_REMOVE  = 3'd1,
		MODE_CLEAR   = 3'd2,
		MODE_RETRY   = 3'd3,
		MODE_PROCESS = 3'd4,
		MODE_OUTCOME = 3'd5
	} mode_t;

	typedef enum logic [3:0] {
		ST_ACK       = 4'd0,
		ST_ENQUEUED  = 4'd1,
		ST_FULL      = 4'd2,
		ST_REMOVED   = 4'd3,
		ST_NOT_FOUND = 4'd4,
		ST_DISPATCH  = 4'd5,
		ST_NONE      = 4'd6,
		ST_BLOCKED   = 4'd7,
		ST_COMPLETED = 4'd8,
		ST_RETRY     = 4'd9,
		ST_DROPPED   = 4'd10,
		ST_NO_OUT    = 4'd11
	} status_t;

	typedef enum logic [2:0] {
		REG_MAX_ATTEMPTS = 3'd0,
		REG_INIT_DELAY   = 3'd1,
		REG_MAX_DELAY    = 3'd2,
		REG_MULT         = 3'd3,
		REG_ONLINE       = 3'd4,
		REG_PAUSED       = 3'd5
	} reg_idx_t;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_MUL,
		FSM_FIN,
		FSM_WAKE,
		FSM_OUT
	} fsm_t;

	// per-slot compare request/response between sequencer and scan unit
	typedef struct packed {
		logic        valid;
		logic [7:0]  prio;
		logic [31:0] seq;
		logic [31:0] due;
		logic        have_best;
		logic [7:0]  best_prio;
		logic [31:0] best_seq;
		logic [31:0] now;
	} cmp_req_t;

	typedef struct packed {
		logic ready_better;
	} cmp_rsp_t;

endpackage

// ----- design/prq_cmp.sv -----
// Shared compare unit used by the slot scan: picks whether a slot beats the current best.
module prq_cmp (
	input  prq_pkg::cmp_req_t req,
	output prq_pkg::cmp_rsp_t rsp
);
	import prq_pkg::*;

	logic [31:0] seq_diff;
	logic        prec;

	always_comb begin
		seq_diff = req.seq - req.best_seq;
		if (req.prio != req.best_prio)
			prec = req.prio > req.best_prio;
		else
			prec = seq_diff[31];
		rsp.ready_better = req.valid && (req.due <= req.now) && (!req.have_best || prec);
	end
endmodule

// ----- design/priority_retry_queue_backoff_top.sv -----
// Top level of the priority retry queue with exponential backoff.
// Usage: one command word enters on in_valid/in_ready; one result word leaves on
// out_valid/out_ready. A sequencer walks the DEPTH slots one per cycle through a
// shared compare unit for dispatch selection, then walks them again for the
// occupancy count and the earliest wake time. Each word passes through the scan,
// finish, multiply and wake states in that order, then the result register loads.
// in_ready is low from acceptance until the result is taken.
// The result register holds its word while out_ready is low, and no new
// command is taken until it leaves.
// Configuration is written through cfg_we/cfg_addr/cfg_wdata at any idle time.
// Reset empties the queue, clears the dispatch flag and loads register
// defaults: max_attempts 5, initial_delay 1000, max_delay 60000,
// multiplier 2.0 (Q8.8), online 1, paused 0.
// Slot storage has no reset; only the valid bits are cleared.
module priority_retry_queue_backoff_top #(
	parameter int DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [23:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  mode,
	input  logic [31:0] now,
	input  logic [7:0]  priority_req,
	input  logic [15:0] payload,
	input  logic [3:0]  entry_id,
	input  logic        success,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  status,
	output logic [3:0]  slot,
	output logic [15:0] job,
	output logic [7:0]  attempt_count,
	output logic [31:0] retry_at,
	output logic [4:0]  occupancy,
	output logic [31:0] next_wake,
	output logic        wake_valid
);
	import prq_pkg::*;

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	// config
	logic [7:0]  max_att_q;
	logic [15:0] init_q;
	logic [23:0] maxd_q;
	logic [15:0] mult_q;
	logic        online_q, paused_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_att_q <= 8'd5;
			init_q    <= 16'd1000;
			maxd_q    <= 24'd60000;
			mult_q    <= 16'd512;
			online_q  <= 1'b1;
			paused_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_MAX_ATTEMPTS: max_att_q <= cfg_wdata[7:0];
				REG_INIT_DELAY:   init_q    <= cfg_wdata[15:0];
				REG_MAX_DELAY:    maxd_q    <= cfg_wdata;
				REG_MULT:         mult_q    <= cfg_wdata[15:0];
				REG_ONLINE:       online_q  <= cfg_wdata[0];
				REG_PAUSED:       paused_q  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// slot storage
	logic [DEPTH-1:0] vld_q;
	logic [7:0]  pri_q [DEPTH];
	logic [15:0] job_q [DEPTH];
	logic [7:0]  try_q [DEPTH];
	logic [31:0] due_q [DEPTH];
	logic [23:0] bo_q  [DEPTH];
	logic [31:0] seq_q [DEPTH];
	logic [31:0] arr_q;
	logic        busy_q;
	logic [IW-1:0] bslot_q;

	// captured command
	mode_t       mode_q;
	logic [31:0] now_q;
	logic [7:0]  prio_q;
	logic [15:0] pay_q;
	logic [3:0]  eid_q;
	logic        succ_q;

	fsm_t st_q, st_d;
	logic [IW-1:0] idx_q;
	logic          have_q;
	logic [IW-1:0] best_q;
	logic [CW-1:0] occ_q;
	logic [31:0]   wake_q;
	logic          any_q;
	logic [39:0]   prod_q;

	// result registers
	status_t     r_status_q;
	logic [3:0]  r_slot_q;
	logic [15:0] r_job_q;
	logic [7:0]  r_try_q;
	logic [31:0] r_retry_q;
	logic        ov_q;

	cmp_req_t creq;
	cmp_rsp_t crsp;

	prq_cmp u_cmp (.req(creq), .rsp(crsp));

	logic last;
	assign last = (idx_q == IW'(DEPTH - 1));

	always_comb begin
		creq.valid     = vld_q[idx_q];
		creq.prio      = pri_q[idx_q];
		creq.seq       = seq_q[idx_q];
		creq.due       = due_q[idx_q];
		creq.have_best = have_q;
		creq.best_prio = pri_q[best_q];
		creq.best_seq  = seq_q[best_q];
		creq.now       = (st_q == FSM_SCAN) ? now_q : 32'hFFFF_FFFF;
	end

	// free slot search: lowest invalid
	logic          free_found;
	logic [IW-1:0] free_idx;
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (!vld_q[i]) begin
				free_found = 1'b1;
				free_idx   = IW'(i);
			end
		end
	end

	logic eid_ok;
	assign eid_ok = ({1'b0, eid_q} < 5'(DEPTH)) || (DEPTH > 16);

	logic [IW-1:0] eidx;
	assign eidx = IW'(eid_q);

	// backoff arithmetic from the registered product
	logic [39:0] prod_sh;
	logic [23:0] dly;
	logic [32:0] due_sum;
	always_comb begin
		prod_sh = prod_q >> 8;
		if (try_q[bslot_q] <= 8'd1)
			dly = ({8'd0, init_q} > maxd_q) ? maxd_q : {8'd0, init_q};
		else
			dly = (prod_sh > {16'd0, maxd_q}) ? maxd_q : prod_sh[23:0];
		due_sum = {1'b0, now_q} + {9'd0, dly};
	end

	// result word of the finish cycle
	logic [7:0]  try_inc;
	status_t     fin_status;
	logic [3:0]  fin_slot;
	logic [15:0] fin_job;
	logic [7:0]  fin_try;
	always_comb begin
		try_inc    = (try_q[best_q] != 8'hFF) ? try_q[best_q] + 1'b1 : 8'hFF;
		fin_status = ST_ACK;
		fin_slot   = '0;
		fin_job    = '0;
		fin_try    = '0;
		unique case (mode_q)
			MODE_ENQ: begin
				fin_job = pay_q;
				if (!free_found) fin_status = ST_FULL;
				else begin
					fin_status = ST_ENQUEUED;
					fin_slot   = 4'(free_idx);
				end
			end
			MODE_REMOVE: begin
				fin_slot = eid_q;
				if (eid_ok && vld_q[eidx]) begin
					fin_job    = job_q[eidx];
					fin_try    = try_q[eidx];
					fin_status = ST_REMOVED;
				end else fin_status = ST_NOT_FOUND;
			end
			MODE_PROCESS: begin
				if (paused_q || !online_q || busy_q) fin_status = ST_BLOCKED;
				else if (!have_q) fin_status = ST_NONE;
				else begin
					fin_status = ST_DISPATCH;
					fin_slot   = 4'(best_q);
					fin_job    = job_q[best_q];
					fin_try    = try_inc;
				end
			end
			MODE_OUTCOME: begin
				if (!busy_q || !vld_q[bslot_q]) fin_status = ST_NO_OUT;
				else begin
					fin_slot = 4'(bslot_q);
					fin_job  = job_q[bslot_q];
					fin_try  = try_q[bslot_q];
					if (succ_q) fin_status = ST_COMPLETED;
					else if (try_q[bslot_q] >= max_att_q) fin_status = ST_DROPPED;
					else fin_status = ST_RETRY;
				end
			end
			default: ;
		endcase
	end

	assign in_ready = (st_q == FSM_IDLE) && !ov_q;

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			FSM_IDLE: if (in_valid && in_ready) st_d = FSM_SCAN;
			FSM_SCAN: if (last) st_d = FSM_FIN;
			FSM_FIN:  st_d = FSM_MUL;
			FSM_MUL:  st_d = FSM_WAKE;
			FSM_WAKE: if (last) st_d = FSM_OUT;
			FSM_OUT:  st_d = FSM_IDLE;
			default:  st_d = FSM_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= FSM_IDLE;
		else         st_q <= st_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			arr_q   <= '0;
			busy_q  <= 1'b0;
			bslot_q <= '0;
			ov_q    <= 1'b0;
			idx_q   <= '0;
			have_q  <= 1'b0;
		end else begin
			if (ov_q && out_ready) ov_q <= 1'b0;
			unique case (st_q)
				FSM_IDLE: begin
					idx_q  <= '0;
					have_q <= 1'b0;
					if (in_valid && in_ready) begin
						mode_q <= mode_t'(mode);
						now_q  <= now;
						prio_q <= priority_req;
						pay_q  <= payload;
						eid_q  <= entry_id;
						succ_q <= success;
					end
				end
				FSM_SCAN: begin
					if (crsp.ready_better) begin
						have_q <= 1'b1;
						best_q <= idx_q;
					end
					idx_q <= last ? '0 : idx_q + 1'b1;
				end
				FSM_FIN: begin
					prod_q     <= {16'd0, bo_q[bslot_q]} * {24'd0, mult_q};
					r_slot_q   <= fin_slot;
					r_job_q    <= fin_job;
					r_try_q    <= fin_try;
					r_retry_q  <= '0;
					r_status_q <= fin_status;
					unique case (mode_q)
						MODE_ENQ: begin
							if (free_found) begin
								vld_q[free_idx] <= 1'b1;
								pri_q[free_idx] <= prio_q;
								job_q[free_idx] <= pay_q;
								try_q[free_idx] <= '0;
								due_q[free_idx] <= now_q;
								bo_q[free_idx]  <= '0;
								seq_q[free_idx] <= arr_q;
								arr_q <= arr_q + 1'b1;
							end
						end
						MODE_REMOVE: begin
							if (eid_ok && vld_q[eidx]) begin
								vld_q[eidx] <= 1'b0;
								if (busy_q && bslot_q == eidx) begin
									busy_q <= 1'b0;
									bslot_q <= '0;
								end
							end
						end
						MODE_CLEAR: begin
							vld_q <= '0;
							busy_q <= 1'b0;
							bslot_q <= '0;
						end
						MODE_RETRY: begin
							for (int i = 0; i < DEPTH; i++)
								if (vld_q[i]) due_q[i] <= now_q;
						end
						MODE_PROCESS: begin
							if (fin_status == ST_DISPATCH) begin
								try_q[best_q] <= try_inc;
								busy_q  <= 1'b1;
								bslot_q <= best_q;
							end
						end
						MODE_OUTCOME: begin
							if (fin_status == ST_NO_OUT) begin
								busy_q <= 1'b0;
								bslot_q <= '0;
							end else if (fin_status == ST_COMPLETED ||
							             fin_status == ST_DROPPED) begin
								vld_q[bslot_q] <= 1'b0;
								busy_q <= 1'b0;
								bslot_q <= '0;
							end
						end
						default: ;
					endcase
				end
				FSM_MUL: begin
					if (mode_q == MODE_OUTCOME && r_status_q == ST_RETRY) begin
						bo_q[bslot_q]  <= dly;
						due_q[bslot_q] <= due_sum[32] ? 32'hFFFF_FFFF : due_sum[31:0];
						r_retry_q      <= due_sum[32] ? 32'hFFFF_FFFF : due_sum[31:0];
						busy_q  <= 1'b0;
						bslot_q <= '0;
					end
					idx_q  <= '0;
					occ_q  <= '0;
					any_q  <= 1'b0;
					wake_q <= '0;
				end
				FSM_WAKE: begin
					if (vld_q[idx_q]) begin
						occ_q <= occ_q + 1'b1;
						any_q <= 1'b1;
						if (!any_q || due_q[idx_q] < wake_q) wake_q <= due_q[idx_q];
					end
					idx_q <= last ? '0 : idx_q + 1'b1;
				end
				FSM_OUT: ov_q <= 1'b1;
				default: ;
			endcase
		end
	end

	assign out_valid     = ov_q;
	assign status        = r_status_q;
	assign slot          = r_slot_q;
	assign job           = r_job_q;
	assign attempt_count = r_try_q;
	assign retry_at      = r_retry_q;
	assign occupancy     = 5'(occ_q);
	assign next_wake     = wake_q;
	assign wake_valid    = any_q && online_q && !paused_q && !busy_q;
endmodule

// ----- design/prq_checker.sv -----
// Port-level checks for the priority retry queue, bound to the top level.
module prq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [3:0]  status,
	input logic [4:0]  occupancy,
	input logic [31:0] next_wake,
	input logic        wake_valid
);
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while result pending");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status))
		else $error("result dropped");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("ready after accept");
	a_empty_wake: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && occupancy == 5'd0 |-> next_wake == 32'd0 && !wake_valid)
		else $error("wake on empty queue");
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= 4'd11) else $error("bad status");
endmodule

bind priority_retry_queue_backoff_top prq_checker u_prq_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .status(status),
	.occupancy(occupancy), .next_wake(next_wake), .wake_valid(wake_valid)
);
